>>> rtl/unpack_eleven_bit_code_frames_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the unpacker RTL.
// ----------------------------------------------------------------------------
`ifndef UNPACK_ELEVEN_BIT_CODE_FRAMES_ASSERT_SVH
`define UNPACK_ELEVEN_BIT_CODE_FRAMES_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define UCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// expression must never be true outside reset
`define UCF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define UCF_ASSERT(label, prop, msg)
`define UCF_ASSERT_NEVER(label, expr, msg)
`endif

`endif

>>> rtl/ucf_pkg.sv
// ----------------------------------------------------------------------------
// ucf_pkg
// Types and constants of the 11-bit code frame unpacker.
// ----------------------------------------------------------------------------
package ucf_pkg;

  localparam int unsigned CODE_BITS     = 11;
  localparam int unsigned MAX_CODEBOOKS = 32;
  localparam int unsigned FRAME_BITS    = 31;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned STORE_W = 18;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned DATA_W  = 56;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd8;
  localparam logic [CFG_W-1:0] CFG_MAX   = CFG_W'(MAX_CODEBOOKS);
  localparam logic [FRAME_BITS-1:0] FRAMES_MAX = '1;

  // output queue
  localparam int unsigned Q_DEPTH = 3;
  localparam int unsigned PTR_W   = 2;

  typedef enum logic {
    KIND_CODE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_LAYOUT   = 2'd2,
    ST_PADDING  = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                 kind;
    logic [CODE_BITS-1:0]  code_value;
    logic [SLOT_W-1:0]     codebook_slot;
    logic [FRAME_BITS-1:0] frame_count;
    status_e               status;
    logic                  last_result;
  } result_t;

  typedef struct packed {
    logic    code_valid;
    logic    status_valid;
    result_t code_res;
    result_t status_res;
  } step_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    nxt = (ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    return nxt;
  endfunction

endpackage

>>> rtl/ucf_step.sv
// ----------------------------------------------------------------------------
// ucf_step
// Bit gathering, slot and frame counting, and end-of-stream status check.
// ----------------------------------------------------------------------------
`include "unpack_eleven_bit_code_frames_assert.svh"

module ucf_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                code_byte_i,
  input  logic                      last_byte_i,
  input  logic [ucf_pkg::CFG_W-1:0] cfg_count_i,
  output ucf_pkg::step_t            step_o
);

  logic [ucf_pkg::STORE_W-1:0]    store_q, store_d;
  logic [ucf_pkg::FILL_W-1:0]     fill_q, fill_d;
  logic [ucf_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [ucf_pkg::FRAME_BITS-1:0] total_q, total_d;
  logic                           ovf_q, ovf_d;

  logic [ucf_pkg::CFG_W-1:0]   count;
  logic [ucf_pkg::STORE_W-1:0] store_cat, store_n;
  logic [ucf_pkg::FILL_W-1:0]  fill_cat, fill_n;
  logic                        has_code;
  logic [7:0]                  pad_mask;
  ucf_pkg::status_e            status;

  assign count = (cfg_count_i > ucf_pkg::CFG_MAX) ? ucf_pkg::CFG_MAX : cfg_count_i;

  // bits above fill are always zero, so OR-in is a plain append
  assign store_cat = store_q | (ucf_pkg::STORE_W'(code_byte_i) << fill_q);
  assign fill_cat  = fill_q + ucf_pkg::FILL_W'(8);
  assign has_code  = fill_cat >= ucf_pkg::FILL_W'(ucf_pkg::CODE_BITS);
  assign store_n   = has_code ? (store_cat >> ucf_pkg::CODE_BITS) : store_cat;
  assign fill_n    = has_code ? fill_cat - ucf_pkg::FILL_W'(ucf_pkg::CODE_BITS) : fill_cat;

  always_comb begin
    slot_d  = slot_q;
    total_d = total_q;
    ovf_d   = ovf_q;
    if (has_code) begin
      if (count == '0) begin
        slot_d = '0;
      end else if (({1'b0, slot_q} + ucf_pkg::CFG_W'(1)) >= count) begin
        slot_d = '0;
        if (total_q == ucf_pkg::FRAMES_MAX) begin
          ovf_d = 1'b1;
        end else begin
          total_d = total_q + ucf_pkg::FRAME_BITS'(1);
        end
      end else begin
        slot_d = slot_q + ucf_pkg::SLOT_W'(1);
      end
    end
  end

  // only looked at when fewer than 8 bits remain
  assign pad_mask = 8'((9'd1 << fill_n[2:0]) - 9'd1);

  always_comb begin
    priority if (count == '0 || total_d == '0 || ovf_d) begin
      status = ucf_pkg::ST_NO_FRAME;
    end else if (slot_d != '0 || fill_n >= ucf_pkg::FILL_W'(8)) begin
      status = ucf_pkg::ST_LAYOUT;
    end else if ((store_n[7:0] & pad_mask) != '0) begin
      status = ucf_pkg::ST_PADDING;
    end else begin
      status = ucf_pkg::ST_OK;
    end
  end

  always_comb begin
    step_o.code_valid               = has_code;
    step_o.status_valid             = last_byte_i;
    step_o.code_res.kind            = ucf_pkg::KIND_CODE;
    step_o.code_res.code_value      = store_cat[ucf_pkg::CODE_BITS-1:0];
    step_o.code_res.codebook_slot   = slot_q;
    step_o.code_res.frame_count     = '0;
    step_o.code_res.status          = ucf_pkg::ST_OK;
    step_o.code_res.last_result     = 1'b0;
    step_o.status_res.kind          = ucf_pkg::KIND_STATUS;
    step_o.status_res.code_value    = '0;
    step_o.status_res.codebook_slot = '0;
    step_o.status_res.frame_count   = total_d;
    step_o.status_res.status        = status;
    step_o.status_res.last_result   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      fill_q  <= '0;
      slot_q  <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        store_q <= '0;
        fill_q  <= '0;
        slot_q  <= '0;
        total_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        store_q <= store_n;
        fill_q  <= fill_n;
        slot_q  <= slot_d;
        total_q <= total_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  `UCF_ASSERT_NEVER(a_fill_range, fill_q > ucf_pkg::FILL_W'(ucf_pkg::CODE_BITS - 1), "fill overrun")
  `UCF_ASSERT(a_store_clean, (store_q >> fill_q) == '0, "stale bits above fill")
  `UCF_ASSERT(a_last_clears, accept_i && last_byte_i |=> fill_q == '0 && total_q == '0 && !ovf_q, "stream state not cleared")

endmodule

>>> rtl/unpack_eleven_bit_code_frames.sv
// ----------------------------------------------------------------------------
// unpack_eleven_bit_code_frames
// LSB-first unpacker of 11-bit codes grouped into frames, with end status.
// ----------------------------------------------------------------------------
// Takes one packed byte per cycle. A byte that completes a code queues one
// code result; a last byte adds a status result behind it, so one that
// also completes a code queues two, sent one per cycle while the output is
// ready. Results wait in a three-entry output queue: input ready is high
// while at most one result is queued, so the input runs at one byte per
// cycle as long as the output drains one per cycle, except that a last byte
// which also completes a code holds input ready low after it. Configuration
// writes are always taken; write only between streams.
`include "unpack_eleven_bit_code_frames_assert.svh"

module unpack_eleven_bit_code_frames (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: codes per frame
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ucf_pkg::CFG_W-1:0]  cfg_data_i,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] code_byte
  input  logic                       s_axis_tlast,   // last_byte
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [10:0] code_value, [15:11] codebook_slot, [46:16] frame_count,
  // [48:47] status, [55:49] zero
  output logic [ucf_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                       m_axis_tuser,   // kind
  output logic                       m_axis_tlast    // last_result
);

  logic [ucf_pkg::CFG_W-1:0] cfg_q;
  ucf_pkg::step_t            step;
  ucf_pkg::result_t          queue_q [ucf_pkg::Q_DEPTH];
  ucf_pkg::result_t          head;
  logic [ucf_pkg::PTR_W-1:0] rd_q, rd_d;
  logic [ucf_pkg::PTR_W-1:0] cnt_q, cnt_d;
  logic [ucf_pkg::PTR_W-1:0] wr0, wr1;
  logic                      in_acc, out_acc;
  logic                      push_code, push_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ucf_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = cnt_q <= ucf_pkg::PTR_W'(1);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  ucf_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .code_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .cfg_count_i (cfg_q),
    .step_o      (step)
  );

  assign push_code = in_acc && step.code_valid;
  assign push_stat = in_acc && step.status_valid;

  // status always lands behind the code of the same byte
  assign wr0 = (rd_q + cnt_q >= ucf_pkg::PTR_W'(ucf_pkg::Q_DEPTH))
               ? rd_q + cnt_q - ucf_pkg::PTR_W'(ucf_pkg::Q_DEPTH)
               : rd_q + cnt_q;
  assign wr1 = ucf_pkg::ptr_inc(wr0);

  always_comb begin
    rd_d  = out_acc ? ucf_pkg::ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q - ucf_pkg::PTR_W'(out_acc)
                  + ucf_pkg::PTR_W'(push_code) + ucf_pkg::PTR_W'(push_stat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_code) begin
      queue_q[wr0] <= step.code_res;
    end
    if (push_stat) begin
      queue_q[push_code ? wr1 : wr0] <= step.status_res;
    end
  end

  assign head          = queue_q[rd_q];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last_result;
  assign m_axis_tdata  = {7'd0, head.status, head.frame_count,
                          head.codebook_slot, head.code_value};

  `UCF_ASSERT_NEVER(a_queue_over, cnt_q > ucf_pkg::PTR_W'(ucf_pkg::Q_DEPTH), "queue overflow")
  `UCF_ASSERT_NEVER(a_rd_range, rd_q > ucf_pkg::PTR_W'(ucf_pkg::Q_DEPTH - 1), "read pointer range")
  `UCF_ASSERT(a_last_tags, m_axis_tvalid |-> m_axis_tlast == m_axis_tuser, "status tag mismatch")
  `UCF_ASSERT(a_push_room, push_code && push_stat |-> cnt_q <= ucf_pkg::PTR_W'(1), "double push without room")

endmodule
